@@ rtl/core/crout_lu_decomposition_assert.svh @@
// Assertion macros for the Crout LU decomposition block.
// Depends on nothing; the including module supplies clk and arst_n.
// Define NO_ASSERTIONS to compile the checks away.
`ifndef CROUT_LU_DECOMPOSITION_ASSERT_SVH
`define CROUT_LU_DECOMPOSITION_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CLU_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("crout_lu_decomposition: check failed");
`define CLU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("crout_lu_decomposition: check failed");
`else
`define CLU_ASSERT_SAME(lbl, ante, cons)
`define CLU_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/core/clu_pkg.sv @@
// Shared types, codes and saturation helpers of the Crout LU decomposition block.
// Depends on nothing; used by the divider, controller, datapath and top level.
package clu_pkg;

	localparam int DEF_MAX_ORDER = 16;
	localparam int WORD_W = 32;
	localparam int FRAC_W = 16;
	localparam int DIV_STEPS = WORD_W + FRAC_W;
	localparam logic [WORD_W-1:0] Q_ONE = 32'h0001_0000;

	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_FACTOR = 2'd1,
		OP_READ   = 2'd2,
		OP_NONE   = 2'd3
	} op_e_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_ZERO_PIVOT = 2'd1,
		ST_SATURATED  = 2'd2
	} status_e_t;

	typedef enum logic [1:0] {
		WR_ZERO = 2'd0,
		WR_ONE  = 2'd1,
		WR_ACC  = 2'd2
	} wr_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ELEM,
		S_A_LOAD,
		S_TERM,
		S_T_MUL,
		S_T_USE,
		S_DIV_WAIT,
		S_RESP
	} state_t;

	typedef struct packed {
		logic    a_wr;
		logic    user_rd;
		logic    a_rd;
		logic    t_rd;
		logic    mul;
		logic    acc_load_a;
		logic    acc_sub_prod;
		logic    div_start;
		logic    div_src_prod;
		logic    acc_load_q;
		logic    acc_sub_q;
		logic    el_wr;
		wr_sel_t el_wr_sel;
		logic    set_piv;
		logic    clr_flags;
		logic    load_out;
		logic    phase_u;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic piv_zero;
	} dp_status_t;

	typedef struct packed {
		logic              sat;
		logic [WORD_W-1:0] val;
	} sat_word_t;

	// Clamp a wide signed value to the Q15.16 word range.
	function automatic sat_word_t sat_wide(input logic signed [63:0] v);
		sat_word_t r;
		if (v > 64'sd2147483647) begin
			r.sat = 1'b1;
			r.val = 32'h7FFF_FFFF;
		end else if (v < -64'sd2147483648) begin
			r.sat = 1'b1;
			r.val = 32'h8000_0000;
		end else begin
			r.sat = 1'b0;
			r.val = v[WORD_W-1:0];
		end
		return r;
	endfunction

	function automatic sat_word_t sub_sat(input logic signed [WORD_W-1:0] a,
			input logic signed [WORD_W-1:0] b);
		logic signed [WORD_W:0] d;
		d = {a[WORD_W-1], a} - {b[WORD_W-1], b};
		return sat_wide(64'(d));
	endfunction

endpackage

@@ rtl/core/crout_lu_decomposition.sv @@
// Crout LU decomposition without pivoting, signed Q15.16. Write and read items are
// accepted, then load the result register; factorize writes each trivial entry directly,
// builds an L entry by subtracting its k terms and a U entry by dividing through the 48-step
// bit-serial divider. One item is in work at a time; a new one is accepted while the last
// result waits. Reset (arst_n low, asynchronous) clears control, flags and sets order to
// MAX_ORDER; the A, L and U memories are not cleared and hold nothing meaningful until written.
module crout_lu_decomposition #(
	parameter int MAX_ORDER = clu_pkg::DEF_MAX_ORDER
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration: order (matrix size in use) in cfg_data[4:0].
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data,
	// Input items.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // row [3:0], col [7:4], value [39:8]
	input  logic [1:0]  s_axis_tuser,  // op [1:0]
	// Result items.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata   // l_value [31:0], u_value [63:32], status [65:64], zero
);
	import clu_pkg::*;

	`include "crout_lu_decomposition_assert.svh"

	localparam int AW = $clog2(MAX_ORDER);
	localparam int CW = $clog2(MAX_ORDER + 1);

	// The effective order is kept already clamped to 1..MAX_ORDER, so the
	// sequencer never has to treat an out-of-range setting.
	logic [CW-1:0]     n_q;
	cmd_t              cmd;
	dp_status_t        st;
	logic [1:0]        op;
	logic [CW-1:0]     i_ix, j_ix, k_ix;
	logic signed [31:0] l_value, u_value;
	logic [1:0]        status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= CW'(MAX_ORDER);
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_data == '0) begin
				n_q <= CW'(1);
			end else if (32'(cfg_data) > MAX_ORDER) begin
				n_q <= CW'(MAX_ORDER);
			end else begin
				n_q <= CW'(cfg_data);
			end
		end
	end

	// The controller sequences columns: for column i it first builds
	// L entries down the column, then U entries along row i.
	clu_ctrl #(
		.CW (CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_op     (s_axis_tuser),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.n         (n_q),
		.st        (st),
		.cmd       (cmd),
		.op        (op),
		.i_ix      (i_ix),
		.j_ix      (j_ix),
		.k_ix      (k_ix)
	);

	clu_dpath #(
		.MAX_ORDER (MAX_ORDER),
		.AW        (AW),
		.CW        (CW)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.st       (st),
		.op       (op),
		.i_ix     (i_ix),
		.j_ix     (j_ix),
		.k_ix     (k_ix),
		.n        (n_q),
		.in_row   (s_axis_tdata[3:0]),
		.in_col   (s_axis_tdata[7:4]),
		.in_value (s_axis_tdata[39:8]),
		.l_value  (l_value),
		.u_value  (u_value),
		.status   (status)
	);

	assign m_axis_tdata = {6'b0, status, u_value, l_value};

	// Only one item is in work: a transaction on the input closes the port next cycle.
	`CLU_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	// A factorize status never comes with element values.
	`CLU_ASSERT_SAME(a_status_alone, m_axis_tvalid && (status != ST_OK), {u_value, l_value} == '0)
	// The status code is one of the three defined outcomes.
	`CLU_ASSERT_SAME(a_status_code, m_axis_tvalid, status <= ST_SATURATED)

endmodule

@@ rtl/core/clu_div.sv @@
// Sequential signed divider computing (num * 2^16) / den, truncated toward zero,
// one quotient bit per cycle, with saturation to Q15.16. Depends on clu_pkg.
module clu_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic signed [31:0]         num,
	input  logic signed [31:0]         den,
	output logic                       done,
	output clu_pkg::sat_word_t         quo
);
	import clu_pkg::*;

	localparam int CNT_W = $clog2(DIV_STEPS + 1);

	logic                        busy_q;
	logic                        done_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        neg_q;
	logic [WORD_W-1:0]           dmag_q;
	logic [WORD_W-1:0]           rem_q;
	logic [DIV_STEPS-1:0]        dvd_q;
	logic [WORD_W:0]             shifted;
	logic                        fits;
	logic [WORD_W-1:0]           num_mag;
	logic [WORD_W-1:0]           den_mag;
	logic signed [DIV_STEPS:0]   q_signed;

	assign num_mag = num[WORD_W-1] ? WORD_W'(-{num[WORD_W-1], num}) : num;
	assign den_mag = den[WORD_W-1] ? WORD_W'(-{den[WORD_W-1], den}) : den;
	assign shifted = {rem_q, dvd_q[DIV_STEPS-1]};
	assign fits    = shifted >= {1'b0, dmag_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q  <= num[WORD_W-1] ^ den[WORD_W-1];
			dmag_q <= den_mag;
			rem_q  <= '0;
			dvd_q  <= {num_mag, {FRAC_W{1'b0}}};
		end else if (busy_q) begin
			rem_q <= fits ? WORD_W'(shifted - {1'b0, dmag_q}) : shifted[WORD_W-1:0];
			dvd_q <= {dvd_q[DIV_STEPS-2:0], fits};
		end
	end

	assign q_signed = neg_q ? -$signed({1'b0, dvd_q}) : $signed({1'b0, dvd_q});
	assign quo      = sat_wide(64'(q_signed));
	assign done     = done_q;

endmodule

@@ rtl/core/clu_ctrl.sv @@
// Controller state machine of the Crout LU decomposition block: handshakes,
// column/row/term counters and datapath commands. Depends on clu_pkg.
module clu_ctrl #(
	parameter int CW = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [1:0]          in_op,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  logic [CW-1:0]       n,
	input  clu_pkg::dp_status_t st,
	output clu_pkg::cmd_t       cmd,
	output logic [1:0]          op,
	output logic [CW-1:0]       i_ix,
	output logic [CW-1:0]       j_ix,
	output logic [CW-1:0]       k_ix
);
	import clu_pkg::*;

	state_t        state_q, state_d;
	logic [1:0]    op_q;
	logic [CW-1:0] i_q, j_q, k_q;
	logic          phase_u_q;
	logic          div_term_q;
	logic          out_valid_q;
	logic          accept;
	logic          j_last, i_last, last_elem;
	logic          elem_fixed;
	logic          term_end;
	logic          advance;
	logic          can_load;

	assign accept    = in_valid && (state_q == S_IDLE);
	assign j_last    = (j_q + CW'(1)) == n;
	assign i_last    = (i_q + CW'(1)) == n;
	assign last_elem = j_last && phase_u_q && i_last;
	// Elements whose value is fixed without arithmetic.
	assign elem_fixed = (j_q < i_q) || (phase_u_q && (j_q == i_q))
		|| (phase_u_q && (j_q > i_q) && st.piv_zero);
	assign term_end  = (k_q == i_q);
	assign advance   = ((state_q == S_ELEM) && elem_fixed) || ((state_q == S_TERM) && term_end);
	assign can_load  = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = (in_op == OP_FACTOR) ? S_ELEM : S_RESP;
				end
			end
			S_ELEM: begin
				if (elem_fixed) begin
					state_d = last_elem ? S_RESP : S_ELEM;
				end else begin
					state_d = S_A_LOAD;
				end
			end
			S_A_LOAD: state_d = phase_u_q ? S_DIV_WAIT : S_TERM;
			S_TERM: begin
				if (term_end) begin
					state_d = last_elem ? S_RESP : S_ELEM;
				end else begin
					state_d = S_T_MUL;
				end
			end
			S_T_MUL: state_d = S_T_USE;
			S_T_USE: state_d = phase_u_q ? S_DIV_WAIT : S_TERM;
			S_DIV_WAIT: begin
				if (st.div_done) begin
					state_d = S_TERM;
				end
			end
			S_RESP: begin
				if (can_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.el_wr_sel = WR_ZERO;
		cmd.phase_u = phase_u_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.a_wr      = (in_op == OP_WRITE);
					cmd.user_rd   = (in_op == OP_READ);
					cmd.clr_flags = (in_op == OP_FACTOR);
				end
			end
			S_ELEM: begin
				if (elem_fixed) begin
					cmd.el_wr     = 1'b1;
					cmd.el_wr_sel = (phase_u_q && (j_q == i_q)) ? WR_ONE : WR_ZERO;
				end else begin
					cmd.a_rd = 1'b1;
				end
			end
			S_A_LOAD: begin
				cmd.div_start  = phase_u_q;
				cmd.acc_load_a = !phase_u_q;
			end
			S_TERM: begin
				if (term_end) begin
					cmd.el_wr     = 1'b1;
					cmd.el_wr_sel = WR_ACC;
					cmd.set_piv   = !phase_u_q && (j_q == i_q);
				end else begin
					cmd.t_rd = 1'b1;
				end
			end
			S_T_MUL: cmd.mul = 1'b1;
			S_T_USE: begin
				cmd.div_start    = phase_u_q;
				cmd.div_src_prod = phase_u_q;
				cmd.acc_sub_prod = !phase_u_q;
			end
			S_DIV_WAIT: begin
				cmd.acc_sub_q  = st.div_done && div_term_q;
				cmd.acc_load_q = st.div_done && !div_term_q;
			end
			S_RESP: cmd.load_out = can_load;
			default: cmd.phase_u = phase_u_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_NONE;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			phase_u_q   <= 1'b0;
			div_term_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				op_q      <= in_op;
				i_q       <= '0;
				j_q       <= '0;
				k_q       <= '0;
				phase_u_q <= 1'b0;
			end
			if (advance) begin
				k_q <= '0;
				if (j_last) begin
					j_q <= '0;
					if (!phase_u_q) begin
						phase_u_q <= 1'b1;
					end else begin
						phase_u_q <= 1'b0;
						i_q       <= i_q + CW'(1);
					end
				end else begin
					j_q <= j_q + CW'(1);
				end
			end
			if ((state_q == S_T_USE) && !phase_u_q) begin
				k_q <= k_q + CW'(1);
			end
			if ((state_q == S_DIV_WAIT) && st.div_done && div_term_q) begin
				k_q <= k_q + CW'(1);
			end
			if (state_q == S_A_LOAD) begin
				div_term_q <= 1'b0;
			end else if (state_q == S_T_USE) begin
				div_term_q <= 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign op        = op_q;
	assign i_ix      = i_q;
	assign j_ix      = j_q;
	assign k_ix      = k_q;

endmodule

@@ rtl/core/clu_dpath.sv @@
// Datapath of the Crout LU decomposition block: A, L and U memories, the
// multiplier, accumulator, pivot, flags and result register. Depends on clu_pkg, clu_div.
module clu_dpath #(
	parameter int MAX_ORDER = clu_pkg::DEF_MAX_ORDER,
	parameter int AW        = $clog2(MAX_ORDER),
	parameter int CW        = $clog2(MAX_ORDER + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  clu_pkg::cmd_t              cmd,
	output clu_pkg::dp_status_t        st,
	input  logic [1:0]                 op,
	input  logic [CW-1:0]              i_ix,
	input  logic [CW-1:0]              j_ix,
	input  logic [CW-1:0]              k_ix,
	input  logic [CW-1:0]              n,
	input  logic [3:0]                 in_row,
	input  logic [3:0]                 in_col,
	input  logic signed [31:0]         in_value,
	output logic signed [31:0]         l_value,
	output logic signed [31:0]         u_value,
	output logic [1:0]                 status
);
	import clu_pkg::*;

	localparam int MEM_DEPTH = 1 << (2 * AW);

	logic signed [WORD_W-1:0] a_mem [MEM_DEPTH];
	logic signed [WORD_W-1:0] l_mem [MEM_DEPTH];
	logic signed [WORD_W-1:0] u_mem [MEM_DEPTH];

	logic [AW-1:0]            row_e, col_e, k_a, in_r, in_c;
	logic [2*AW-1:0]          el_addr, in_addr, l_raddr, u_raddr;
	logic                     in_rng_max, in_rng_n;
	logic signed [WORD_W-1:0] a_rd_q, l_rd_q, u_rd_q;
	logic signed [63:0]       prod_s1;
	sat_word_t                prod_w;
	sat_word_t                q_w;
	sat_word_t                sub_prod, sub_q;
	logic signed [WORD_W-1:0] acc_q;
	logic signed [WORD_W-1:0] piv_q;
	logic signed [WORD_W-1:0] wr_data;
	logic                     div_done;
	logic signed [WORD_W-1:0] div_num;
	logic                     zero_piv_q, sat_q;
	logic                     rd_ok_q;
	logic signed [WORD_W-1:0] l_out_q, u_out_q;
	logic [1:0]               status_q;

	assign row_e   = cmd.phase_u ? i_ix[AW-1:0] : j_ix[AW-1:0];
	assign col_e   = cmd.phase_u ? j_ix[AW-1:0] : i_ix[AW-1:0];
	assign k_a     = k_ix[AW-1:0];
	assign in_r    = AW'(in_row);
	assign in_c    = AW'(in_col);
	assign el_addr = {row_e, col_e};
	assign in_addr = {in_r, in_c};
	assign l_raddr = cmd.user_rd ? in_addr : {row_e, k_a};
	assign u_raddr = cmd.user_rd ? in_addr : {k_a, col_e};

	assign in_rng_max = (32'(in_row) < MAX_ORDER) && (32'(in_col) < MAX_ORDER);
	assign in_rng_n   = (32'(in_row) < 32'(n)) && (32'(in_col) < 32'(n));

	always_comb begin
		case (cmd.el_wr_sel)
			WR_ONE:  wr_data = Q_ONE;
			WR_ACC:  wr_data = acc_q;
			default: wr_data = '0;
		endcase
	end

	// Memories: one write and one registered read port each.
	always_ff @(posedge clk) begin
		if (cmd.a_wr && in_rng_max) begin
			a_mem[in_addr] <= in_value;
		end
		if (cmd.a_rd) begin
			a_rd_q <= a_mem[el_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.el_wr && !cmd.phase_u) begin
			l_mem[el_addr] <= wr_data;
		end
		if (cmd.user_rd || cmd.t_rd) begin
			l_rd_q <= l_mem[l_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.el_wr && cmd.phase_u) begin
			u_mem[el_addr] <= wr_data;
		end
		if (cmd.user_rd || cmd.t_rd) begin
			u_rd_q <= u_mem[u_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_s1 <= l_rd_q * u_rd_q;
		end
	end

	assign prod_w   = sat_wide(prod_s1 >>> FRAC_W);
	assign sub_prod = sub_sat(acc_q, prod_w.val);
	assign sub_q    = sub_sat(acc_q, q_w.val);
	assign div_num  = cmd.div_src_prod ? prod_w.val : a_rd_q;

	clu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (piv_q),
		.done   (div_done),
		.quo    (q_w)
	);

	always_ff @(posedge clk) begin
		if (cmd.acc_load_a) begin
			acc_q <= a_rd_q;
		end else if (cmd.acc_sub_prod) begin
			acc_q <= sub_prod.val;
		end else if (cmd.acc_load_q) begin
			acc_q <= q_w.val;
		end else if (cmd.acc_sub_q) begin
			acc_q <= sub_q.val;
		end
		if (cmd.set_piv) begin
			piv_q <= acc_q;
		end
		if (cmd.user_rd) begin
			rd_ok_q <= in_rng_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_piv_q <= 1'b0;
			sat_q      <= 1'b0;
		end else begin
			if (cmd.clr_flags) begin
				zero_piv_q <= 1'b0;
				sat_q      <= 1'b0;
			end else begin
				if (cmd.set_piv && (acc_q == '0)) begin
					zero_piv_q <= 1'b1;
				end
				if ((cmd.acc_sub_prod && (prod_w.sat || sub_prod.sat))
						|| (cmd.div_start && cmd.div_src_prod && prod_w.sat)
						|| (cmd.acc_load_q && q_w.sat)
						|| (cmd.acc_sub_q && (q_w.sat || sub_q.sat))) begin
					sat_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			l_out_q  <= '0;
			u_out_q  <= '0;
			status_q <= ST_OK;
			case (op)
				OP_READ: begin
					l_out_q <= rd_ok_q ? l_rd_q : '0;
					u_out_q <= rd_ok_q ? u_rd_q : '0;
				end
				OP_FACTOR: begin
					status_q <= zero_piv_q ? ST_ZERO_PIVOT : (sat_q ? ST_SATURATED : ST_OK);
				end
				default: status_q <= ST_OK;
			endcase
		end
	end

	assign st.div_done = div_done;
	assign st.piv_zero = (piv_q == '0);
	assign l_value     = l_out_q;
	assign u_value     = u_out_q;
	assign status      = status_q;

endmodule
